>>> rtl/fws_pkg.sv
// Package for the FIFO with value search: command codes, status codes,
// the decoded operation type and the item and result records.
// No dependencies.
package fws_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_SRCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_SRCH,
        OP_NOP
    } fws_op_t;

    typedef struct packed {
        fws_op_t            op;
        logic signed [31:0] value;
    } fws_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         position;
        logic signed [31:0] data_out;
        logic [4:0]         occupancy;
    } fws_result_t;

endpackage

>>> rtl/fws_front.sv
// Front end: accepts input words, decodes the command and holds the decoded
// items in a two-entry queue for the execution unit. Depends on fws_pkg.
module fws_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    output logic               item_valid,
    output fws_pkg::fws_item_t item,
    input  logic               item_pop
);
    import fws_pkg::*;

    fws_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       accept;
    fws_item_t  decoded;

    always_comb
    begin
        decoded.value = value;
        case (cmd)
            CMD_ENQ:  decoded.op = OP_ENQ;
            CMD_DEQ:  decoded.op = OP_DEQ;
            CMD_SRCH: decoded.op = OP_SRCH;
            default:  decoded.op = OP_NOP;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign accept     = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, accept} - {1'b0, item_pop};
        end
    end

endmodule

>>> rtl/fws_exec.sv
// Execution unit: owns the ring memory with its head, tail and count, and
// runs enqueue, dequeue and the one-entry-per-cycle search. Depends on fws_pkg.
module fws_exec #(
    parameter int DEPTH = fws_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  fws_pkg::fws_item_t   item,
    output logic                 item_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output fws_pkg::fws_result_t res
);
    import fws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SRCH
    } state_t;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    state_t             state_reg,    state_next;
    logic [AW-1:0]      head_reg,     head_next;
    logic [AW-1:0]      tail_reg,     tail_next;
    logic [CW-1:0]      count_reg,    count_next;
    logic [CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;
    logic signed [31:0] key_reg,      key_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_idx_next = scan_idx_reg;
        key_next      = key_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = head_reg;
        res.status    = ST_OK;
        res.position  = 5'd0;
        res.data_out  = '0;
        res.occupancy = 5'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                // Starting only with room in the result queue guarantees the
                // later push of this item always fits.
                if (item_valid && !res_full)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        OP_ENQ:
                        begin
                            res_push = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                tail_next     = ring_next(tail_reg);
                                count_next    = count_reg + CW'(1);
                                res.occupancy = 5'(count_reg + CW'(1));
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_push   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DEQ;
                            end
                        end
                        OP_SRCH:
                        begin
                            key_next = item.value;
                            if (count_reg == '0)
                            begin
                                res_push   = 1'b1;
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                scan_cnt_next = '0;
                                scan_idx_next = ring_next(head_reg);
                                state_next    = S_SRCH;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                res_push      = 1'b1;
                res.data_out  = rd_data_reg;
                res.occupancy = 5'(count_reg - CW'(1));
                head_next     = ring_next(head_reg);
                count_next    = count_reg - CW'(1);
                state_next    = S_IDLE;
            end
            S_SRCH:
            begin
                // Compare the entry read last cycle while fetching the next one.
                rd_addr = scan_idx_reg;
                if (rd_data_reg == key_reg)
                begin
                    res_push     = 1'b1;
                    res.position = 5'(scan_cnt_reg + CW'(1));
                    state_next   = S_IDLE;
                end
                else if (scan_cnt_reg + CW'(1) == count_reg)
                begin
                    res_push   = 1'b1;
                    res.status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                    scan_idx_next = ring_next(scan_idx_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= item.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            scan_idx_reg <= '0;
            key_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            scan_idx_reg <= scan_idx_next;
            key_reg      <= key_next;
        end
    end

endmodule

>>> rtl/fws_outq.sv
// Result queue: two entries between the execution unit and the result port,
// so the front keeps accepting while a result waits. Depends on fws_pkg.
module fws_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  fws_pkg::fws_result_t res,
    output logic                 res_full,
    output logic                 empty,
    input  logic                 pop,
    output fws_pkg::fws_result_t head
);
    import fws_pkg::*;

    fws_result_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        take;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign take     = pop && !empty;
    assign head     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, res_push} - {1'b0, take};
        end
    end

endmodule

>>> rtl/fifo_with_value_search.sv
// Top level of the FIFO with value search: front decoder, execution unit and
// result queue. Depends on fws_pkg, fws_front, fws_exec and fws_outq.
//
// A FIFO of DEPTH signed 32-bit words driven by commands: enqueue, dequeue,
// and search for the first entry equal to a value (1-based position from the
// head). Every accepted command yields exactly one result with the occupancy
// after the operation. The execution unit works on one command at a time
// through a single-read-port memory with registered read data. Enqueue and
// unused commands finish in the idle state, dequeue adds a read state, and a
// search scans from the head to a match or the last entry. Two-entry command
// and result queues let both sides stall freely.
module fifo_with_value_search #(
    parameter int DEPTH = fws_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic [4:0]         position,
    output logic signed [31:0] data_out,
    output logic [4:0]         occupancy
);
    import fws_pkg::*;

    logic        item_valid;
    logic        item_pop;
    fws_item_t   item;
    logic        res_push;
    logic        res_full;
    fws_result_t res;
    fws_result_t head;

    fws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    fws_exec #(
        .DEPTH (DEPTH)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    fws_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign status    = head.status;
    assign position  = head.position;
    assign data_out  = head.data_out;
    assign occupancy = head.occupancy;

    // A dropped enqueue can only happen with the queue holding DEPTH words.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FULL) |-> occupancy == 5'(DEPTH))
        else $error("full status with wrong occupancy");

    // An empty dequeue reports no data and no entries.
    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EMPTY) |-> (occupancy == 5'd0 && data_out == '0))
        else $error("empty status with data or entries");

    // A failed search carries no position.
    a_nf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_NOTFOUND) |-> position == 5'd0)
        else $error("not-found result with a position");

    // The execution unit never pushes into a full result queue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("result queue overrun");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for fifo_with_value_search: directed and random command words,
// a transaction-level predictor of the ring, and in-order result checking.
// Depends on fws_pkg and the RTL top level fifo_with_value_search.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fws_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = PTR_W + 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 4 * DEPTH;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_PER_PHASE = 250;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op_code;
        logic signed [31:0] word;
    } command_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         cmd = CMD_ENQ;
    logic signed [31:0] value = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         status;
    logic [4:0]         position;
    logic signed [31:0] data_out;
    logic [4:0]         occupancy;

    command_word_t pending_words[$];
    fws_result_t   predicted_results[$];
    logic          word_taken = 1'b0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // Shadow copy of the ring that the predictor walks.
    logic signed [31:0] ring_words[DEPTH];
    logic [PTR_W-1:0]   head_ptr = '0;
    logic [PTR_W-1:0]   tail_ptr = '0;
    logic [FILL_W-1:0]  fill_count = '0;

    logic signed [31:0] value_pool[8];

    fifo_with_value_search #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .status    (status),
        .position  (position),
        .data_out  (data_out),
        .occupancy (occupancy)
    );

    always #6 clk = ~clk;

    function automatic logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    function automatic fws_result_t apply_command(logic [1:0] op_code,
                                                  logic signed [31:0] word);
        fws_result_t      res;
        logic [PTR_W-1:0] slot;
        int               k;
        res = '0;
        case (op_code)
            CMD_ENQ:
            begin
                if (int'(fill_count) == DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ring_words[tail_ptr] = word;
                    tail_ptr = ring_advance(tail_ptr);
                    fill_count = fill_count + FILL_W'(1);
                end
            end
            CMD_DEQ:
            begin
                if (fill_count == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data_out = ring_words[head_ptr];
                    head_ptr = ring_advance(head_ptr);
                    fill_count = fill_count - FILL_W'(1);
                end
            end
            CMD_SRCH:
            begin
                res.status = ST_NOTFOUND;
                slot = head_ptr;
                for (k = 0; k < int'(fill_count) && res.status == ST_NOTFOUND; k++)
                begin
                    if (ring_words[slot] == word)
                    begin
                        res.status = ST_OK;
                        res.position = 5'(k + 1);
                    end
                    slot = ring_advance(slot);
                end
            end
            default:
            begin
                // The unused command leaves the ring alone and reports ok.
            end
        endcase
        res.occupancy = 5'(fill_count);
        return res;
    endfunction

    task automatic check_result(fws_result_t want, fws_result_t got);
        if (got.status !== want.status || got.position !== want.position ||
            got.data_out !== want.data_out || got.occupancy !== want.occupancy)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display({"result mismatch at %0t: expected status %0d position %0d",
                          " data %0d occ %0d, got status %0d position %0d data %0d occ %0d"},
                         $realtime, want.status, want.position, want.data_out,
                         want.occupancy, got.status, got.position, got.data_out,
                         got.occupancy);
        end
    endtask

    // Acceptance of command words and result words, sampled at the rising edge.
    always @(posedge clk)
    begin
        fws_result_t got;
        if (rst_n)
        begin
            word_taken <= push && !full;
            if (push && !full)
                predicted_results.push_back(apply_command(cmd, value));
            if (pop && !empty)
            begin
                got = {status, position, data_out, occupancy};
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"unexpected result at %0t: status %0d position %0d",
                                  " data %0d occ %0d"},
                                 $realtime, status, position, data_out, occupancy);
                end
                else
                begin
                    check_result(predicted_results.pop_front(), got);
                end
            end
        end
    end

    // Sender: a word stays on the ports until it has been taken.
    always @(negedge clk)
    begin
        command_word_t next_word;
        if (rst_n && (!push || word_taken))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_word = pending_words.pop_front();
                push <= 1'b1;
                cmd <= next_word.op_code;
                value <= next_word.word;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_command(logic [1:0] op_code, logic signed [31:0] word);
        command_word_t item;
        item.op_code = op_code;
        item.word = word;
        pending_words.push_back(item);
    endtask

    // Random traffic in bursts, each with its own enqueue bias so the ring
    // swings between empty and full. Half the values come from a small pool
    // so that searches hit, often with duplicates in the ring.
    task automatic queue_random_commands(int target);
        int                 queued;
        int                 burst_left;
        int                 enq_pct;
        int                 roll;
        logic [1:0]         op_code;
        logic signed [31:0] word;
        queued = 0;
        burst_left = 0;
        enq_pct = 50;
        while (queued < target)
        begin
            if (burst_left == 0)
            begin
                roll = $urandom_range(2);
                enq_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
                burst_left = $urandom_range(48, 16);
            end
            roll = $urandom_range(99);
            if (roll < 2)
                op_code = CMD_UNUSED;
            else if (roll < 2 + enq_pct * 98 / 100)
                op_code = CMD_ENQ;
            else if ($urandom_range(1) == 0)
                op_code = CMD_DEQ;
            else
                op_code = CMD_SRCH;
            if ($urandom_range(1) == 0)
                word = value_pool[$urandom_range(7)];
            else
                word = $urandom;
            add_command(op_code, word);
            if (op_code != CMD_UNUSED)
            begin
                queued++;
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_words.size() != 0 || push || predicted_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        queue_random_commands(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    initial
    begin
        int k;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, extreme values, first-match search, the
        // unused command, filling to the brim and the dropped enqueue.
        add_command(CMD_DEQ, 32'sd5);
        add_command(CMD_SRCH, '0);
        add_command(CMD_ENQ, 32'sh8000_0000);
        add_command(CMD_ENQ, 32'sh7FFF_FFFF);
        add_command(CMD_ENQ, '0);
        add_command(CMD_ENQ, -32'sd1);
        add_command(CMD_SRCH, 32'sh7FFF_FFFF);
        add_command(CMD_SRCH, -32'sd1);
        add_command(CMD_DEQ, '0);
        add_command(CMD_SRCH, 32'sh8000_0000);
        add_command(CMD_UNUSED, 32'sh5A5A_A5A5);
        for (k = 0; k < DEPTH - 3; k++)
            add_command(CMD_ENQ, 32'sh1234_0000 + k);
        add_command(CMD_ENQ, 32'sh7777_7777);
        add_command(CMD_SRCH, 32'sh1234_0000 + DEPTH - 4);
        wait_for_drain();

        run_phase(0, 0);
        run_phase(75, 0);
        run_phase(0, 75);
        run_phase(24, 24);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
